/* src/multi_switch_debouncer_macros.svh */
// ---------------------------------------------------------------------------
// multi_switch_debouncer_macros: assertion macros for the switch debouncer
// Defines clocked assertion wrappers; an empty form when NO_ASSERTIONS is set.
// ---------------------------------------------------------------------------
`ifndef MULTI_SWITCH_DEBOUNCER_MACROS_SVH
`define MULTI_SWITCH_DEBOUNCER_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, checked on clk and disabled during rst
`define MSD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");
// next-cycle implication, checked on clk and disabled during rst
`define MSD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");
`else
`define MSD_ASSERT_NOW(label, ante, cons)
`define MSD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* src/msd_pkg.sv */
// ---------------------------------------------------------------------------
// msd_pkg: shared types and constants of the switch debouncer
// Slot count, register indexes, configuration and per-slot state types.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package msd_pkg;

  // number of switch slots (1 to 32)
  localparam int SLOT_COUNT   = 8;
  localparam int SLOT_W       = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  // slots shown in the output level word and covered by the masks
  localparam int MASK_W       = 8;
  localparam int LEVEL_W      = (SLOT_COUNT < MASK_W) ? SLOT_COUNT : MASK_W;

  localparam int TIME_W     = 32;
  localparam int DEBOUNCE_W = 15;
  localparam int ACTIVE_W   = 4;
  localparam int INDEX_W    = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BUTTON_MASK    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PULLUP_MASK    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LINK_MASK      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_START_LEVELS   = 3'd5;

  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 15'd10;

  // operation codes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_POLL = 1'b1;

  typedef struct packed {
    logic [DEBOUNCE_W-1:0] debounce_ms;
    logic [ACTIVE_W-1:0]   active_slots;
    logic [MASK_W-1:0]     button_mask;
    logic [MASK_W-1:0]     pullup_mask;
    logic [MASK_W-1:0]     output_link_mask;
  } cfg_t;

  typedef struct packed {
    logic              pending;
    logic [TIME_W-1:0] timing_start;
    logic              stable;
  } slot_t;

  // mask bit of a slot; slots past the mask width read as zero
  function automatic logic mask_bit(input logic [MASK_W-1:0] mask,
                                    input logic [INDEX_W-1:0] idx);
    logic bit_val;
    bit_val = 1'b0;
    for (int i = 0; i < MASK_W; i++) begin
      if (idx == INDEX_W'(i)) begin
        bit_val = mask[i];
      end
    end
    return bit_val;
  endfunction

endpackage

/* src/multi_switch_debouncer.sv */
// ---------------------------------------------------------------------------
// multi_switch_debouncer: debouncer for a bank of switch slots
// Ticks advance a millisecond counter; polls debounce one slot per beat.
// ---------------------------------------------------------------------------
//  channel | handshake                 | payload
//  --------+---------------------------+-------------------------------------
//  item    | item_valid / item_stall   | operation, switch_index, pin_level
//  result  | result_valid/result_stall | switched, toggle_state,
//          |                           | output_levels, bad_index
//  config  | cfg_write                 | cfg_index, cfg_data
//
//  One beat in and one beat out per cycle while result_stall is low; a beat
//  passes an input register, the slot update, then the result register.
//  Slot state and the counter update when a beat leaves the input register,
//  so the next beat sees them at once.
//  rst is synchronous and restores register defaults and all slot state.
//  A stalled result holds its register; the input register still takes a
//  beat while the result waits, then stalls until the result moves.
`timescale 1ns / 1ps

`include "multi_switch_debouncer_macros.svh"

module multi_switch_debouncer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_stall,
  input  logic                              operation,
  input  logic [msd_pkg::INDEX_W-1:0]       switch_index,
  input  logic                              pin_level,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic                              switched,
  output logic                              toggle_state,
  output logic [msd_pkg::MASK_W-1:0]        output_levels,
  output logic                              bad_index,
  input  logic                              cfg_write,
  input  logic [msd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [msd_pkg::CFG_DATA_W-1:0]    cfg_data
);

  msd_pkg::cfg_t                       cfg;
  logic [msd_pkg::TIME_W-1:0]          time_ms;
  logic [msd_pkg::SLOT_COUNT-1:0]      output_level;
  logic [msd_pkg::SLOT_COUNT-1:0]      output_level_next;
  logic [msd_pkg::SLOT_COUNT-1:0]      start_levels;
  msd_pkg::slot_t                      slots [msd_pkg::SLOT_COUNT];

  logic                                in_full;
  logic                                in_op;
  logic [msd_pkg::INDEX_W-1:0]         in_idx;
  logic                                in_lvl;

  logic                                advance;
  logic [msd_pkg::INDEX_W-1:0]         limit;
  logic                                bad;
  logic                                poll_ok;
  logic [msd_pkg::SLOT_W-1:0]          slot_sel;
  msd_pkg::slot_t                      slot_new;
  logic                                hit;
  logic                                flip;
  logic [msd_pkg::MASK_W-1:0]          levels_next;

  // move a beat out of the input register when the result side has room
  assign advance    = in_full && (!result_valid || !result_stall);
  assign item_stall = in_full && !advance;

  // slot range check against min(active_slots, SLOT_COUNT)
  always_comb begin
    if (msd_pkg::INDEX_W'(cfg.active_slots) < msd_pkg::INDEX_W'(msd_pkg::SLOT_COUNT)) begin
      limit = msd_pkg::INDEX_W'(cfg.active_slots);
    end else begin
      limit = msd_pkg::INDEX_W'(msd_pkg::SLOT_COUNT);
    end
  end

  assign bad      = (in_op == msd_pkg::OP_POLL) && (in_idx >= limit);
  assign poll_ok  = (in_op == msd_pkg::OP_POLL) && !bad;
  assign slot_sel = in_idx[msd_pkg::SLOT_W-1:0];

  msd_step u_step (
    .cfg      (cfg),
    .time_ms  (time_ms),
    .idx      (in_idx),
    .level    (in_lvl),
    .slot_cur (slots[slot_sel]),
    .slot_new (slot_new),
    .hit      (hit)
  );

  // flip a linked output on a completed report
  assign flip = poll_ok && hit && msd_pkg::mask_bit(cfg.output_link_mask, in_idx);

  always_comb begin
    output_level_next = output_level;
    if (flip) begin
      output_level_next[slot_sel] = ~output_level[slot_sel];
    end
  end

  // pack the visible output levels
  always_comb begin
    levels_next = '0;
    for (int i = 0; i < msd_pkg::LEVEL_W; i++) begin
      levels_next[i] = output_level_next[i];
    end
  end

  // start levels as loaded by a register write; hidden slots start low
  always_comb begin
    start_levels = '0;
    for (int i = 0; i < msd_pkg::LEVEL_W; i++) begin
      start_levels[i] = cfg_data[i];
    end
  end

  // capture an accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!item_stall) begin
      in_full <= item_valid;
    end
    if (item_valid && !item_stall) begin
      in_op  <= operation;
      in_idx <= switch_index;
      in_lvl <= pin_level;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms      <= msd_pkg::DEBOUNCE_RESET;
      cfg.active_slots     <= '0;
      cfg.button_mask      <= '0;
      cfg.pullup_mask      <= '0;
      cfg.output_link_mask <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        msd_pkg::REG_DEBOUNCE_MS: cfg.debounce_ms      <= cfg_data;
        msd_pkg::REG_ACTIVE:      cfg.active_slots     <= cfg_data[msd_pkg::ACTIVE_W-1:0];
        msd_pkg::REG_BUTTON_MASK: cfg.button_mask      <= cfg_data[msd_pkg::MASK_W-1:0];
        msd_pkg::REG_PULLUP_MASK: cfg.pullup_mask      <= cfg_data[msd_pkg::MASK_W-1:0];
        msd_pkg::REG_LINK_MASK:   cfg.output_link_mask <= cfg_data[msd_pkg::MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // advance the millisecond counter on a tick
  always_ff @(posedge clk) begin
    if (rst) begin
      time_ms <= '0;
    end else if (advance && (in_op == msd_pkg::OP_TICK)) begin
      time_ms <= time_ms + msd_pkg::TIME_W'(1);
    end
  end

  // write back the polled slot
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < msd_pkg::SLOT_COUNT; i++) begin
        slots[i] <= '0;
      end
    end else if (advance && poll_ok) begin
      slots[slot_sel] <= slot_new;
    end
  end

  // output levels: load start levels on write, flip on linked reports
  always_ff @(posedge clk) begin
    if (rst) begin
      output_level <= '0;
    end else if (cfg_write && (cfg_index == msd_pkg::REG_START_LEVELS)) begin
      output_level <= start_levels;
    end else if (advance) begin
      output_level <= output_level_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
    if (advance) begin
      switched      <= poll_ok && hit;
      toggle_state  <= poll_ok && slot_new.stable;
      output_levels <= levels_next;
      bad_index     <= bad;
    end
  end

  // checks
  `MSD_ASSERT_NOW(a_bad_no_switch, result_valid && bad_index, !switched)
  `MSD_ASSERT_NEXT(a_fill_result, in_full && !result_valid, result_valid)
  `MSD_ASSERT_NEXT(a_tick_count, advance && (in_op == msd_pkg::OP_TICK), time_ms == $past(time_ms) + 32'd1)
  `MSD_ASSERT_NEXT(a_level_hold, !flip && !cfg_write, $stable(output_level))

endmodule

/* src/msd_step.sv */
// ---------------------------------------------------------------------------
// msd_step: debounce update of one polled slot
// Applies circuit polarity and mode to a slot's state for one poll.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module msd_step (
  input  msd_pkg::cfg_t                  cfg,
  input  logic [msd_pkg::TIME_W-1:0]     time_ms,
  input  logic [msd_pkg::INDEX_W-1:0]    idx,
  input  logic                           level,
  input  msd_pkg::slot_t                 slot_cur,
  output msd_pkg::slot_t                 slot_new,
  output logic                           hit
);

  logic                        lvl;
  logic                        button;
  logic [msd_pkg::TIME_W-1:0]  start_mid;
  logic                        pend_mid;
  logic [msd_pkg::TIME_W-1:0]  span;
  logic                        elapsed;

  // fold the pull-up polarity into the pressed level
  assign lvl    = level ^ msd_pkg::mask_bit(cfg.pullup_mask, idx);
  assign button = msd_pkg::mask_bit(cfg.button_mask, idx);

  // toggle mode: start timing on a change seen while not pending
  always_comb begin
    pend_mid  = slot_cur.pending;
    start_mid = slot_cur.timing_start;
    if (!button && (lvl != slot_cur.stable) && !slot_cur.pending) begin
      pend_mid  = 1'b1;
      start_mid = time_ms;
    end
  end

  // elapsed time wraps modulo 2^32
  assign span    = time_ms - start_mid;
  assign elapsed = span >= msd_pkg::TIME_W'(cfg.debounce_ms);

  // settle the slot for this poll
  always_comb begin
    slot_new = slot_cur;
    hit      = 1'b0;
    if (button) begin
      if (lvl) begin
        slot_new.pending      = 1'b1;
        slot_new.timing_start = time_ms;
      end else if (slot_cur.pending && elapsed) begin
        slot_new.pending = 1'b0;
        hit              = 1'b1;
      end
    end else begin
      slot_new.pending      = pend_mid;
      slot_new.timing_start = start_mid;
      if (pend_mid && elapsed) begin
        slot_new.stable  = ~slot_cur.stable;
        slot_new.pending = 1'b0;
        hit              = 1'b1;
      end
    end
  end

endmodule

/* sim/multi_switch_debouncer_test.sv */
// ---------------------------------------------------------------------------
// multi_switch_debouncer_test: self-checking bench for the switch debouncer
// Drives tick and poll beats through several register settings and idle
// patterns; a mirror of the slot bank predicts each result beat in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module multi_switch_debouncer_test;

  // register indexes the block does not decode
  localparam logic [msd_pkg::CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [msd_pkg::CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  typedef struct {
    logic                       switched;
    logic                       toggle;
    logic [msd_pkg::MASK_W-1:0] levels;
    logic                       bad;
  } slot_report_t;

  // mirror of the slot bank and the queue of reports it predicts
  class debounce_mirror;
    logic [msd_pkg::DEBOUNCE_W-1:0] debounce;
    logic [msd_pkg::ACTIVE_W-1:0]   active;
    logic [msd_pkg::MASK_W-1:0]     btn_mask;
    logic [msd_pkg::MASK_W-1:0]     pull_mask;
    logic [msd_pkg::MASK_W-1:0]     link_mask;
    logic [msd_pkg::TIME_W-1:0]     now_ms;
    logic                           pend [msd_pkg::SLOT_COUNT];
    logic [msd_pkg::TIME_W-1:0]     start_ms [msd_pkg::SLOT_COUNT];
    logic                           stable [msd_pkg::SLOT_COUNT];
    logic                           out_lvl [msd_pkg::SLOT_COUNT];
    slot_report_t                   due [$];
    int                             mismatches;

    function new();
      debounce   = msd_pkg::DEBOUNCE_RESET;
      active     = '0;
      btn_mask   = '0;
      pull_mask  = '0;
      link_mask  = '0;
      now_ms     = '0;
      mismatches = 0;
      for (int i = 0; i < msd_pkg::SLOT_COUNT; i++) begin
        pend[i]     = 1'b0;
        start_ms[i] = '0;
        stable[i]   = 1'b0;
        out_lvl[i]  = 1'b0;
      end
    endfunction

    // slots past the mask width read as zero
    function logic slot_bit(logic [msd_pkg::MASK_W-1:0] mask, int slot);
      return (slot < msd_pkg::MASK_W) ? mask[slot] : 1'b0;
    endfunction

    function logic [msd_pkg::MASK_W-1:0] levels_word();
      logic [msd_pkg::MASK_W-1:0] w;
      w = '0;
      for (int i = 0; i < msd_pkg::SLOT_COUNT && i < msd_pkg::MASK_W; i++) w[i] = out_lvl[i];
      return w;
    endfunction

    function logic elapsed(int slot);
      logic [msd_pkg::TIME_W-1:0] diff;
      diff = now_ms - start_ms[slot];
      return diff >= msd_pkg::TIME_W'(debounce);
    endfunction

    function void write_reg(logic [msd_pkg::CFG_IDX_W-1:0] idx,
                            logic [msd_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        msd_pkg::REG_DEBOUNCE_MS: debounce  = data[msd_pkg::DEBOUNCE_W-1:0];
        msd_pkg::REG_ACTIVE:      active    = data[msd_pkg::ACTIVE_W-1:0];
        msd_pkg::REG_BUTTON_MASK: btn_mask  = data[msd_pkg::MASK_W-1:0];
        msd_pkg::REG_PULLUP_MASK: pull_mask = data[msd_pkg::MASK_W-1:0];
        msd_pkg::REG_LINK_MASK:   link_mask = data[msd_pkg::MASK_W-1:0];
        msd_pkg::REG_START_LEVELS: begin
          for (int i = 0; i < msd_pkg::SLOT_COUNT && i < msd_pkg::MASK_W; i++)
            out_lvl[i] = data[i];
        end
        default: ;
      endcase
    endfunction

    function int slot_limit();
      return (active < msd_pkg::SLOT_COUNT) ? int'(active) : msd_pkg::SLOT_COUNT;
    endfunction

    // predict the report for one accepted beat
    function void take_item(logic op, logic [msd_pkg::INDEX_W-1:0] idx, logic lvl);
      slot_report_t r;
      int   s;
      logic eff;
      logic hit;
      r   = '{switched: 1'b0, toggle: 1'b0, levels: '0, bad: 1'b0};
      hit = 1'b0;
      s   = int'(idx);
      if (op == msd_pkg::OP_TICK) begin
        now_ms = now_ms + 1;
      end else if (s >= slot_limit()) begin
        r.bad = 1'b1;
      end else begin
        eff = lvl ^ slot_bit(pull_mask, s);
        if (slot_bit(btn_mask, s)) begin
          // restart while pressed, report on a late enough release
          if (eff) begin
            pend[s]     = 1'b1;
            start_ms[s] = now_ms;
          end else if (pend[s] && elapsed(s)) begin
            pend[s] = 1'b0;
            hit     = 1'b1;
          end
        end else begin
          // start timing on a change, flip once the period has passed
          if (eff != stable[s] && !pend[s]) begin
            pend[s]     = 1'b1;
            start_ms[s] = now_ms;
          end
          if (pend[s] && elapsed(s)) begin
            stable[s] = ~stable[s];
            pend[s]   = 1'b0;
            hit       = 1'b1;
          end
        end
        if (hit && slot_bit(link_mask, s)) out_lvl[s] = ~out_lvl[s];
        r.switched = hit;
        r.toggle   = stable[s];
      end
      r.levels = levels_word();
      due.push_back(r);
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    // compare one accepted result beat with the oldest prediction
    function void match_report(logic sw, logic tg, logic [msd_pkg::MASK_W-1:0] lv,
                               logic bad);
      slot_report_t r;
      if (due.size() == 0) begin
        $display("%0t: result beat with no prediction, expected none actual %0h/%0h/%0h/%0h",
                 $time, sw, tg, lv, bad);
        mismatches++;
        return;
      end
      r = due.pop_front();
      check_field("switched", 32'(r.switched), 32'(sw));
      check_field("toggle_state", 32'(r.toggle), 32'(tg));
      check_field("output_levels", 32'(r.levels), 32'(lv));
      check_field("bad_index", 32'(r.bad), 32'(bad));
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           item_valid = 1'b0;
  logic                           item_stall;
  logic                           operation = msd_pkg::OP_TICK;
  logic [msd_pkg::INDEX_W-1:0]    switch_index = '0;
  logic                           pin_level = 1'b0;
  logic                           result_valid;
  logic                           result_stall = 1'b0;
  logic                           switched;
  logic                           toggle_state;
  logic [msd_pkg::MASK_W-1:0]     output_levels;
  logic                           bad_index;
  logic                           cfg_write = 1'b0;
  logic [msd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [msd_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  debounce_mirror bank = new();
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  hold_req = 1'b0;
  logic raw_want [msd_pkg::SLOT_COUNT];

  multi_switch_debouncer dut (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .operation     (operation),
    .switch_index  (switch_index),
    .pin_level     (pin_level),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .switched      (switched),
    .toggle_state  (toggle_state),
    .output_levels (output_levels),
    .bad_index     (bad_index),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #10 clk = ~clk;

  // hard stop for a hung run
  initial begin
    #4_000_000;
    $display("simulation failed");
    $finish;
  end

  // receiver: random stall, with a long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        result_stall <= 1'b1;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 79;
        result_stall <= 1'b1;
      end else begin
        result_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // check each result beat as it leaves
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      bank.match_report(switched, toggle_state, output_levels, bad_index);
    end
  end

  // offer one beat, idling first at random, and hold it until accepted
  task automatic send_item(logic op, logic [msd_pkg::INDEX_W-1:0] idx, logic lvl);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      item_valid <= 1'b0;
    end
    @(negedge clk);
    item_valid   <= 1'b1;
    operation    <= op;
    switch_index <= idx;
    pin_level    <= lvl;
    do @(posedge clk); while (item_stall);
    bank.take_item(op, idx, lvl);
  endtask

  // stop offering and wait for every predicted result
  task automatic drain();
    @(negedge clk);
    item_valid <= 1'b0;
    while (bank.due.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(logic [msd_pkg::CFG_IDX_W-1:0] idx,
                           logic [msd_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    bank.write_reg(idx, data);
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // reprogram every register while idle
  task automatic configure(int deb, int act, int btn, int pull, int link, int lvls);
    drain();
    write_reg(msd_pkg::REG_DEBOUNCE_MS, msd_pkg::CFG_DATA_W'(deb));
    write_reg(msd_pkg::REG_ACTIVE, msd_pkg::CFG_DATA_W'(act));
    write_reg(msd_pkg::REG_BUTTON_MASK, msd_pkg::CFG_DATA_W'(btn));
    write_reg(msd_pkg::REG_PULLUP_MASK, msd_pkg::CFG_DATA_W'(pull));
    write_reg(msd_pkg::REG_LINK_MASK, msd_pkg::CFG_DATA_W'(link));
    write_reg(msd_pkg::REG_START_LEVELS, msd_pkg::CFG_DATA_W'(lvls));
    end_writes();
  endtask

  // mostly held levels per slot with bounce, plus ticks and stray indexes
  task automatic run_random(int count);
    int r;
    int s;
    int lim;
    logic lvl;
    lim = bank.slot_limit();
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < 40 || (r >= 48 && lim == 0)) begin
        send_item(msd_pkg::OP_TICK, msd_pkg::INDEX_W'($urandom_range(255)),
                  1'($urandom_range(1)));
      end else if (r < 48) begin
        send_item(msd_pkg::OP_POLL, msd_pkg::INDEX_W'($urandom_range(255)),
                  1'($urandom_range(1)));
      end else begin
        s = $urandom_range(lim - 1);
        if ($urandom_range(99) < 10) raw_want[s] = ~raw_want[s];
        lvl = ($urandom_range(99) < 85) ? raw_want[s] : 1'($urandom_range(1));
        send_item(msd_pkg::OP_POLL, msd_pkg::INDEX_W'(s),
                  lvl ^ bank.slot_bit(bank.pull_mask, s));
      end
    end
  endtask

  initial begin
    for (int i = 0; i < msd_pkg::SLOT_COUNT; i++) raw_want[i] = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 14;
    recv_idle_pct = 53;

    // defaults: no slot in use
    send_item(msd_pkg::OP_TICK, 8'h00, 1'b0);
    send_item(msd_pkg::OP_POLL, 8'h00, 1'b1);
    send_item(msd_pkg::OP_POLL, 8'hFF, 1'b0);

    configure(2, 8, 'h03, 'h02, 'h0F, 'hA0);
    write_reg(REG_SPARE_6, 15'h7FFF);
    write_reg(REG_SPARE_7, 15'h5555);
    end_writes();

    // button slot: press, re-press, early release, late release
    send_item(msd_pkg::OP_POLL, 8'd0, 1'b1);
    send_item(msd_pkg::OP_TICK, 8'h80, 1'b1);
    send_item(msd_pkg::OP_TICK, 8'h7F, 1'b0);
    send_item(msd_pkg::OP_POLL, 8'd0, 1'b1);
    send_item(msd_pkg::OP_POLL, 8'd0, 1'b0);
    send_item(msd_pkg::OP_TICK, 8'h00, 1'b0);
    send_item(msd_pkg::OP_TICK, 8'h00, 1'b0);
    send_item(msd_pkg::OP_POLL, 8'd0, 1'b0);
    // pulled-up button slot: low level is a press
    send_item(msd_pkg::OP_POLL, 8'd1, 1'b0);
    send_item(msd_pkg::OP_TICK, 8'h00, 1'b0);
    send_item(msd_pkg::OP_TICK, 8'h00, 1'b0);
    send_item(msd_pkg::OP_POLL, 8'd1, 1'b1);
    // toggle slot: change, bounce back, then settle
    send_item(msd_pkg::OP_POLL, 8'd2, 1'b1);
    send_item(msd_pkg::OP_POLL, 8'd2, 1'b0);
    send_item(msd_pkg::OP_TICK, 8'h00, 1'b0);
    send_item(msd_pkg::OP_TICK, 8'h00, 1'b0);
    send_item(msd_pkg::OP_POLL, 8'd2, 1'b1);
    send_item(msd_pkg::OP_POLL, 8'd7, 1'b1);
    // indexes past the active count
    send_item(msd_pkg::OP_POLL, 8'd8, 1'b1);
    send_item(msd_pkg::OP_POLL, 8'd200, 1'b0);

    configure(3, 8, 'h0F, 'h3C, 'hFF, 'h00);
    run_random(180);
    configure(0, 8, 'hAA, 'hFF, 'h55, 'hFF);
    run_random(90);
    hold_req = 1'b1;
    run_random(90);

    send_idle_pct = 53;
    recv_idle_pct = 14;
    configure(2, 5, $urandom_range(32767), $urandom_range(32767),
              $urandom_range(32767), $urandom_range(32767));
    run_random(180);
    configure(32767, 8, 'h33, 'h0F, 'hF0, 'h5A);
    run_random(90);
    drain();
    run_random(90);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    configure(1, 1, 'h01, 'h00, 'h01, 'h00);
    run_random(180);
    configure(4, 15, $urandom_range(255), $urandom_range(255),
              $urandom_range(255), $urandom_range(255));
    run_random(180);

    drain();
    repeat (10) @(posedge clk);
    if (bank.mismatches == 0 && bank.due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* multi_switch_debouncer.f */
+incdir+src
src/msd_pkg.sv
src/msd_step.sv
src/multi_switch_debouncer.sv
sim/multi_switch_debouncer_test.sv
